// ===== rtl/uart_baud_divisor_select_top_macros.svh =====
// Assertion macros shared by the checker of the baud divisor selection block.
// Depends on nothing; included by the checker file.
`ifndef UART_BAUD_DIVISOR_SELECT_TOP_MACROS_SVH
`define UART_BAUD_DIVISOR_SELECT_TOP_MACROS_SVH

// Clocked assertion with asynchronous active-low reset as disable.
`define UDSEL_ASSERT(lbl, clk_s, rst_n, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) prop) \
		else $error("udsel check failed");

// A signal holds its value in the cycle after the condition.
`define UDSEL_ASSERT_HOLD(lbl, clk_s, rst_n, cond, sig) \
	`UDSEL_ASSERT(lbl, clk_s, rst_n, (cond) |=> $stable(sig))

`endif

// ===== rtl/udsel_pkg.sv =====
// Shared types and constants of the UART baud divisor selection block.
// Used by the front, divider, back and top level modules.
package udsel_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned DIV_W  = 16;
	localparam int unsigned CNT_W  = $clog2(WORD_W);

	localparam logic [WORD_W-1:0] CLOCK_HZ_RESET = 32'd32000000;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_TOO_FAST = 2'd1;
	localparam logic [1:0] ST_TOO_SLOW = 2'd2;

	// Window on q/64 that keeps the slow prescale (divisor 10 to 254).
	localparam logic [25:0] SLOW_Q_MIN = 26'd11;
	localparam logic [25:0] SLOW_Q_MAX = 26'd255;
	// Below this q/16 the fast prescale is used.
	localparam logic [27:0] MID_Q_LIMIT = 28'd257;
	// Above this q/16 the divisor does not fit in 16 bits.
	localparam logic [27:0] MID_Q_MAX = 28'd65536;
	// Below this q/4 the fast divisor is 1 or less.
	localparam logic [29:0] FAST_Q_MIN = 30'd3;

	typedef struct packed {
		logic [WORD_W-1:0] baud;
		logic              zero;
	} item_t;

	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] num;
		logic [WORD_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] quo;
	} div_rsp_t;

endpackage

// ===== rtl/udsel_front.sv =====
// Front end: accepts requested baud rates, flags zero rates and queues them.
// Depends on udsel_pkg for the queued item type.
module udsel_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [31:0]           requested_baud,
	input  logic                  pop,
	output logic                  q_valid,
	output udsel_pkg::item_t      q_item
);

	udsel_pkg::item_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       do_pop;

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != 2'd0);
	assign do_pop   = pop && q_valid;
	assign q_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q].baud <= requested_baud;
			mem_q[wr_ptr_q].zero <= (requested_baud == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ===== rtl/udsel_div.sv =====
// Radix-2 restoring divider for 32-bit unsigned operands, one bit per cycle.
// Depends on udsel_pkg for the request and response structs.
module udsel_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  udsel_pkg::div_req_t   req,
	output udsel_pkg::div_rsp_t   rsp
);

	logic                                busy_q;
	logic                                done_q;
	logic [udsel_pkg::CNT_W-1:0]         cnt_q;
	logic [udsel_pkg::WORD_W-1:0]        rem_q;
	logic [udsel_pkg::WORD_W-1:0]        quo_q;
	logic [udsel_pkg::WORD_W-1:0]        den_q;
	logic [udsel_pkg::WORD_W:0]          trial;
	logic [udsel_pkg::WORD_W:0]          diff;
	logic                                ge;

	assign trial = {rem_q, quo_q[udsel_pkg::WORD_W-1]};
	assign ge    = (trial >= {1'b0, den_q});
	assign diff  = trial - {1'b0, den_q};

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[udsel_pkg::WORD_W-1:0] : trial[udsel_pkg::WORD_W-1:0];
			quo_q <= {quo_q[udsel_pkg::WORD_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == '1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== rtl/udsel_back.sv =====
// Back end: sequences the two divisions, picks the prescale and holds the result.
// Depends on udsel_pkg; drives the shared divider through its request struct.
module udsel_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [31:0]           clock_hz,
	input  logic                  q_valid,
	input  udsel_pkg::item_t      q_item,
	output logic                  pop,
	output udsel_pkg::div_req_t   div_req,
	input  udsel_pkg::div_rsp_t   div_rsp,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [15:0]           divisor,
	output logic                  wide_mode,
	output logic                  high_speed,
	output logic [31:0]           actual_baud,
	output logic [1:0]            status
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_QUOT,
		S_SEL,
		S_ACT,
		S_EMIT
	} state_t;

	state_t              state_q;
	udsel_pkg::div_req_t req_q;
	logic [31:0]         quot_q;
	logic [15:0]         res_div_q;
	logic                res_wide_q;
	logic                res_hs_q;
	logic [31:0]         res_act_q;
	logic [1:0]          res_st_q;
	logic                out_valid_q;
	logic [15:0]         out_div_q;
	logic                out_wide_q;
	logic                out_hs_q;
	logic [31:0]         out_act_q;
	logic [1:0]          out_st_q;

	logic [25:0] q6;
	logic [27:0] q4;
	logic [29:0] q2;
	logic        slow_ok;
	logic        use_fast;
	logic        sel_err;
	logic [1:0]  sel_st;
	logic [15:0] sel_div;
	logic [31:0] sel_den;
	logic        out_free;
	logic        start_div;
	logic        do_emit;

	assign q6 = quot_q[31:6];
	assign q4 = quot_q[31:4];
	assign q2 = quot_q[31:2];

	always_comb begin
		slow_ok  = (q6 >= udsel_pkg::SLOW_Q_MIN) && (q6 <= udsel_pkg::SLOW_Q_MAX);
		use_fast = !slow_ok && (q4 < udsel_pkg::MID_Q_LIMIT);
		sel_err  = 1'b0;
		sel_st   = udsel_pkg::ST_OK;
		if (slow_ok) begin
			sel_div = 16'(q6 - 26'd1);
			sel_den = {q6, 6'b0};
		end else if (use_fast) begin
			sel_div = 16'(q2 - 30'd1);
			sel_den = {q2, 2'b0};
			if (q2 < udsel_pkg::FAST_Q_MIN) begin
				sel_err = 1'b1;
				sel_st  = udsel_pkg::ST_TOO_FAST;
			end
		end else begin
			sel_div = 16'(q4 - 28'd1);
			sel_den = {q4, 4'b0};
			if (q4 > udsel_pkg::MID_Q_MAX) begin
				sel_err = 1'b1;
				sel_st  = udsel_pkg::ST_TOO_SLOW;
			end
		end
	end

	assign pop       = (state_q == S_IDLE) && q_valid;
	assign out_free  = !out_valid_q || !out_stall;
	assign div_req   = req_q;
	assign start_div = ((state_q == S_IDLE) && q_valid && !q_item.zero)
		|| ((state_q == S_SEL) && !sel_err);
	assign do_emit   = (state_q == S_EMIT) && out_free;

	assign out_valid   = out_valid_q;
	assign divisor     = out_div_q;
	assign wide_mode   = out_wide_q;
	assign high_speed  = out_hs_q;
	assign actual_baud = out_act_q;
	assign status      = out_st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_q       <= '0;
			quot_q      <= '0;
			res_div_q   <= '0;
			res_wide_q  <= 1'b0;
			res_hs_q    <= 1'b0;
			res_act_q   <= '0;
			res_st_q    <= udsel_pkg::ST_OK;
			out_valid_q <= 1'b0;
			out_div_q   <= '0;
			out_wide_q  <= 1'b0;
			out_hs_q    <= 1'b0;
			out_act_q   <= '0;
			out_st_q    <= udsel_pkg::ST_OK;
		end else begin
			req_q.start <= start_div;
			if (do_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						if (q_item.zero) begin
							res_div_q  <= '0;
							res_wide_q <= 1'b0;
							res_hs_q   <= 1'b0;
							res_act_q  <= '0;
							res_st_q   <= udsel_pkg::ST_TOO_FAST;
							state_q    <= S_EMIT;
						end else begin
							req_q.num   <= clock_hz;
							req_q.den   <= q_item.baud;
							state_q     <= S_QUOT;
						end
					end
				end
				S_QUOT: begin
					if (div_rsp.done) begin
						quot_q  <= div_rsp.quo;
						state_q <= S_SEL;
					end
				end
				S_SEL: begin
					if (sel_err) begin
						res_div_q  <= '0;
						res_wide_q <= 1'b0;
						res_hs_q   <= 1'b0;
						res_act_q  <= '0;
						res_st_q   <= sel_st;
						state_q    <= S_EMIT;
					end else begin
						res_div_q   <= sel_div;
						res_wide_q  <= !slow_ok;
						res_hs_q    <= use_fast;
						res_st_q    <= udsel_pkg::ST_OK;
						req_q.num   <= clock_hz;
						req_q.den   <= sel_den;
						state_q     <= S_ACT;
					end
				end
				S_ACT: begin
					if (div_rsp.done) begin
						res_act_q <= div_rsp.quo;
						state_q   <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_div_q   <= res_div_q;
						out_wide_q  <= res_wide_q;
						out_hs_q    <= res_hs_q;
						out_act_q   <= res_act_q;
						out_st_q    <= res_st_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/uart_baud_divisor_select_top.sv =====
// Top level of the UART baud divisor selection block.
// Depends on udsel_pkg, udsel_front, udsel_div and udsel_back.
//
// The input channel (in_valid, in_stall, requested_baud) carries one requested
// baud rate per transfer. The output channel (out_valid, out_stall) returns one
// result per request, in order: divisor, wide_mode, high_speed, actual_baud and
// status. The clock_hz register is to be loaded through cfg_valid and cfg_data
// only while the block is idle; the user is bound to this and the block itself
// does not enforce it. cfg_ready is always high. A request waits in a two-entry
// queue, then takes two passes through the shared radix-2 divider: one for
// clock_hz / requested_baud, one for the actual baud. The back end finishes one
// request before it takes the next. A zero baud skips both passes; a selection
// error skips the second pass.
// Up to two requests are taken while earlier work is in progress.
// When the receiver stalls, the result is held in the output register, the back
// end finishes the next result and then waits, and in_stall rises once the
// queue is full. Reset empties the queue, drops any result and sets clock_hz
// to 32000000.
module uart_baud_divisor_select_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] requested_baud,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] divisor,
	output logic        wide_mode,
	output logic        high_speed,
	output logic [31:0] actual_baud,
	output logic [1:0]  status
);

	logic [31:0]         clock_hz_q;
	logic                q_valid;
	logic                pop;
	udsel_pkg::item_t    q_item;
	udsel_pkg::div_req_t div_req;
	udsel_pkg::div_rsp_t div_rsp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q <= udsel_pkg::CLOCK_HZ_RESET;
		end else if (cfg_valid && cfg_ready) begin
			clock_hz_q <= cfg_data;
		end
	end

	udsel_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.requested_baud (requested_baud),
		.pop            (pop),
		.q_valid        (q_valid),
		.q_item         (q_item)
	);

	udsel_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	udsel_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.clock_hz    (clock_hz_q),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.pop         (pop),
		.div_req     (div_req),
		.div_rsp     (div_rsp),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.divisor     (divisor),
		.wide_mode   (wide_mode),
		.high_speed  (high_speed),
		.actual_baud (actual_baud),
		.status      (status)
	);

endmodule

// ===== rtl/udsel_checker.sv =====
// Port-level checks of the UART baud divisor selection block, bound to the top.
// Depends on uart_baud_divisor_select_top_macros.svh for the assertion macros.
`include "uart_baud_divisor_select_top_macros.svh"

module udsel_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] divisor,
	input logic        wide_mode,
	input logic        high_speed,
	input logic [31:0] actual_baud,
	input logic [1:0]  status
);

	logic res_ok;
	logic res_err;
	logic fields_zero;

	assign res_ok      = out_valid && (status == udsel_pkg::ST_OK);
	assign res_err     = out_valid && (status != udsel_pkg::ST_OK);
	assign fields_zero = (divisor == 16'd0) && (actual_baud == 32'd0) && !wide_mode
		&& !high_speed;

	`UDSEL_ASSERT(a_status_code, clk, arst_n, out_valid |-> (status <= udsel_pkg::ST_TOO_SLOW))
	`UDSEL_ASSERT(a_error_zero, clk, arst_n, res_err |-> fields_zero)
	`UDSEL_ASSERT(a_fast_is_wide, clk, arst_n, (out_valid && high_speed) |-> wide_mode)
	`UDSEL_ASSERT(a_ok_nonzero_rate, clk, arst_n, res_ok |-> (actual_baud != 32'd0))
	`UDSEL_ASSERT_HOLD(a_stall_hold, clk, arst_n, out_valid && out_stall, actual_baud)

endmodule

bind uart_baud_divisor_select_top udsel_checker u_udsel_checker (.*);

// ===== verif/uart_baud_divisor_select_top_test.sv =====
// Self-checking testbench for the UART baud divisor selection block.
// Depends on udsel_pkg and uart_baud_divisor_select_top; drives random requests
// and clock settings and compares each result with a table or in-line predictor.
`timescale 1ns / 100ps

module uart_baud_divisor_select_top_test;

	typedef struct packed {
		logic [15:0] divisor;
		logic        wide;
		logic        fast;
		logic [31:0] actual;
		logic [1:0]  status;
	} baud_result_t;

	typedef struct packed {
		logic [31:0]  baud;
		logic         known;
		baud_result_t want;
	} probe_row_t;

	localparam int PROBE_ROWS = 23;
	localparam int RANDOM_PER_PHASE = 204;
	localparam int CLOCK_SETTINGS = 6;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] requested_baud = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] divisor;
	logic        wide_mode;
	logic        high_speed;
	logic [31:0] actual_baud;
	logic [1:0]  status;

	logic [31:0]  osc_hz = udsel_pkg::CLOCK_HZ_RESET;
	baud_result_t pending_results[$];
	int           mismatch_count = 0;
	int           idle_level = 0;
	int           phase_no = 0;
	int           stall_left = 0;
	logic         hold_long = 1'b0;

	probe_row_t probe_rows [0:PROBE_ROWS-1] = '{
		'{32'd0,          1'b1, '{16'd0, 1'b0, 1'b0, 32'd0, udsel_pkg::ST_TOO_FAST}},
		'{32'hFFFF_FFFF,  1'b1, '{16'd0, 1'b0, 1'b0, 32'd0, udsel_pkg::ST_TOO_FAST}},
		'{32'd1,          1'b1, '{16'd0, 1'b0, 1'b0, 32'd0, udsel_pkg::ST_TOO_SLOW}},
		'{32'd9600,       1'b1, '{16'd51, 1'b0, 1'b0, 32'd9615, udsel_pkg::ST_OK}},
		'{32'd115200,     1'b1, '{16'd68, 1'b1, 1'b1, 32'd115942, udsel_pkg::ST_OK}},
		'{32'd2000000,    1'b1, '{16'd3, 1'b1, 1'b1, 32'd2000000, udsel_pkg::ST_OK}},
		'{32'd4000000,    1'b1, '{16'd0, 1'b0, 1'b0, 32'd0, udsel_pkg::ST_TOO_FAST}},
		'{32'd2,          1'b0, '0},
		'{32'd2666666,    1'b0, '0},
		'{32'd2666667,    1'b0, '0},
		'{32'd300,        1'b0, '0},
		'{32'd45454,      1'b0, '0},
		'{32'd45455,      1'b0, '0},
		'{32'd1953,       1'b0, '0},
		'{32'd1954,       1'b0, '0},
		'{32'd30,         1'b0, '0},
		'{32'd31,         1'b0, '0},
		'{32'd7812,       1'b0, '0},
		'{32'd488,        1'b0, '0},
		'{32'h8000_0000,  1'b0, '0},
		'{32'h5555_5555,  1'b0, '0},
		'{32'hAAAA_AAAA,  1'b0, '0},
		'{32'h0000_FFFF,  1'b0, '0}
	};

	logic [31:0] clock_settings [0:CLOCK_SETTINGS-1] = '{
		32'd1, 32'hFFFF_FFFF, 32'd18432000, 32'd0, 32'd48000000, 32'd32000000
	};

	uart_baud_divisor_select_top uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.requested_baud (requested_baud),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.divisor        (divisor),
		.wide_mode      (wide_mode),
		.high_speed     (high_speed),
		.actual_baud    (actual_baud),
		.status         (status)
	);

	always #1 clk = ~clk;

	function automatic baud_result_t select_divisor(input logic [31:0] osc,
			input logic [31:0] baud);
		baud_result_t r;
		logic [31:0]  q;
		logic [31:0]  qs;
		logic [31:0]  scale;
		logic         wide;
		logic         fast;
		logic [63:0]  den;
		r = '0;
		wide = 1'b0;
		fast = 1'b0;
		if (baud == 32'd0) begin
			r.status = udsel_pkg::ST_TOO_FAST;
			return r;
		end
		q = osc / baud;
		scale = 32'd64;
		if (q / 64 < 11 || q / 64 > 255) begin
			wide = 1'b1;
			scale = 32'd16;
			if (q / 16 < 257) begin
				fast = 1'b1;
				scale = 32'd4;
			end
		end
		qs = q / scale;
		if (fast && qs < 3) begin
			r.status = udsel_pkg::ST_TOO_FAST;
			return r;
		end
		if (qs > 32'd65536) begin
			r.status = udsel_pkg::ST_TOO_SLOW;
			return r;
		end
		den = 64'(qs) * 64'(scale);
		r.divisor = 16'(qs - 32'd1);
		r.wide = wide;
		r.fast = fast;
		r.actual = 32'(64'(osc) / den);
		r.status = udsel_pkg::ST_OK;
		return r;
	endfunction

	function automatic logic [31:0] pick_baud(input logic [31:0] osc);
		logic [31:0] b;
		case ($urandom_range(0, 7))
			0: b = $urandom;
			1: b = $urandom_range(1, 400);
			2, 3: b = osc / $urandom_range(1, 800);
			4: b = osc / $urandom_range(800, 2000000);
			5: b = $urandom_range(0, 3);
			6: b = 32'hFFFF_FFFF - $urandom_range(0, 15);
			default: b = osc / $urandom_range(8, 16);
		endcase
		return b;
	endfunction

	function automatic bit idle_now();
		if (idle_level == 0)
			return 1'b0;
		return $urandom_range(0, (idle_level == 1) ? 15 : 4) == 0;
	endfunction

	task automatic note_mismatch(input string msg);
		$display("%0t: mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_result();
		baud_result_t want;
		if (pending_results.size() == 0) begin
			note_mismatch("result with no request waiting");
			return;
		end
		want = pending_results.pop_front();
		if (divisor !== want.divisor)
			note_mismatch($sformatf("divisor %0d, expected %0d", divisor, want.divisor));
		if (wide_mode !== want.wide)
			note_mismatch($sformatf("wide_mode %0b, expected %0b", wide_mode, want.wide));
		if (high_speed !== want.fast)
			note_mismatch($sformatf("high_speed %0b, expected %0b", high_speed, want.fast));
		if (actual_baud !== want.actual)
			note_mismatch($sformatf("actual_baud %0d, expected %0d", actual_baud,
				want.actual));
		if (status !== want.status)
			note_mismatch($sformatf("status %0d, expected %0d", status, want.status));
	endtask

	// One request transfer; the expectation is queued at the accepting edge.
	task automatic offer_baud(input logic [31:0] b, input baud_result_t exp_res);
		requested_baud <= b;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(exp_res);
		if (idle_now()) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic write_clock(input logic [31:0] value);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		osc_hz = value;
	endtask

	task automatic run_random(input int count);
		logic [31:0] b;
		for (int i = 0; i < count; i++) begin
			b = pick_baud(osc_hz);
			offer_baud(b, select_divisor(osc_hz, b));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				check_result();
			if (hold_long) begin
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (idle_now()) begin
				stall_left = $urandom_range(0, 17);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// The receiver holds off for a long stretch so that the block fills up.
	initial begin
		wait (phase_no == 2);
		@(posedge clk);
		hold_long <= 1'b1;
		repeat (700) @(posedge clk);
		hold_long <= 1'b0;
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		logic [31:0] setting;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_level = 1;
		for (int i = 0; i < PROBE_ROWS; i++) begin
			offer_baud(probe_rows[i].baud, probe_rows[i].known ? probe_rows[i].want :
				select_divisor(osc_hz, probe_rows[i].baud));
		end
		run_random(RANDOM_PER_PHASE);
		for (int p = 0; p < CLOCK_SETTINGS; p++) begin
			setting = clock_settings[p];
			if (setting == 32'd0)
				setting = $urandom_range(100000, 200000000);
			write_clock(setting);
			phase_no = p + 1;
			case (p)
				0, 3: idle_level = 2;
				2, 5: idle_level = 0;
				default: idle_level = 1;
			endcase
			run_random(RANDOM_PER_PHASE);
		end
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
